[sv/mesh_iv_index_update_fsm_defines.svh]
// assertion macros for the iv index update block
`ifndef MESH_IV_INDEX_UPDATE_FSM_DEFINES_SVH
`define MESH_IV_INDEX_UPDATE_FSM_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset, on clk
`define MIVU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MIVU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIVU_ASSERT(lbl, prop, msg)
`define MIVU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/mivu_pkg.sv]
`default_nettype none

package mivu_pkg;

    localparam int unsigned TICK_SECONDS = 1200;
    localparam int unsigned MAX_GAP      = 42;
    localparam int unsigned TICKS_96H    = 96 * 3600 / TICK_SECONDS;
    localparam int unsigned TICKS_144H   = 144 * 3600 / TICK_SECONDS;
    localparam int unsigned TICKS_MAX    = MAX_GAP * 2 * TICKS_96H;

    // operate tick counter width, holds TICKS_MAX
    localparam int unsigned TICK_W = $clog2(TICKS_MAX + 1);

    // seconds / 1200 as (seconds >> 4) / 75, done by reciprocal multiply
    localparam int unsigned SECS_W     = 24;
    localparam int unsigned DIV_PRE    = 4;
    localparam int unsigned DIV_IN_W   = SECS_W - DIV_PRE;
    localparam int unsigned DIV_BY     = TICK_SECONDS / (1 << DIV_PRE);
    localparam int unsigned DIV_SHIFT  = 26;
    localparam int unsigned DIV_MULT   = ((1 << DIV_SHIFT) + DIV_BY - 1) / DIV_BY;
    localparam int unsigned DIV_MULT_W = $clog2(DIV_MULT + 1);
    localparam int unsigned DIV_PROD_W = DIV_IN_W + DIV_MULT_W;
    localparam int unsigned DIV_Q_W    = DIV_PROD_W - DIV_SHIFT;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_BEACON = 2'd1,
        REQ_LOAD   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LOWER = 2'd1,
        ST_GAP   = 2'd2,
        ST_EARLY = 2'd3
    } status_t;

    typedef enum logic {
        IV_NORMAL      = 1'b0,
        IV_IN_PROGRESS = 1'b1
    } iv_state_t;

endpackage

`default_nettype wire

[sv/mesh_iv_index_update_fsm.sv]
// iv index update state machine
//
// input channel: in_valid / in_stall with req_type, iv_value, update_flag,
// transport_busy and seconds_value. output channel: out_valid / out_stall
// with status, cur_iv_index, tx_iv_index, in_progress, transit_pending and
// clear_pulse. every item gives exactly one result item.
// config: cfg_we writes cfg_wdata into test_mode; write only while idle.
//
// an item is first held in the input register and its result is then
// written into the output register, where out_valid marks it.
// the iv state is updated in that same single pass, so one item per cycle
// is taken as long as the output side keeps up.
// when out_stall holds, the result waits in the output register and one
// more item is taken into the input register; then in_stall rises.
// reset clears the index, the update state, the tick count, the pending
// flag, test_mode and both valid flags.
`default_nettype none
`include "mesh_iv_index_update_fsm_defines.svh"

module mesh_iv_index_update_fsm (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] iv_value,
    input  wire logic        update_flag,
    input  wire logic        transport_busy,
    input  wire logic [23:0] seconds_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      cur_iv_index,
    output logic [31:0]      tx_iv_index,
    output logic             in_progress,
    output logic             transit_pending,
    output logic             clear_pulse
);

    localparam int unsigned TW = mivu_pkg::TICK_W;

    // handshake and control
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_adv;
    logic in_take;
    logic test_mode_reg;

    // input register
    logic [1:0]  s1_req_reg;
    logic [31:0] s1_iv_reg;
    logic        s1_flag_reg;
    logic        s1_busy_reg;
    logic [23:0] s1_secs_reg;

    // iv state
    logic [31:0]           iv_index_reg, iv_index_next;
    mivu_pkg::iv_state_t   state_reg, state_next;
    logic [TW-1:0]         ticks_reg, ticks_next;
    logic                  pending_reg, pending_next;

    // result register
    mivu_pkg::status_t     status_reg, status_next;
    logic [31:0]           cur_reg;
    logic [31:0]           tx_reg, tx_next;
    logic                  prog_reg;
    logic                  pend_out_reg;
    logic                  clr_reg, clr_next;

    // datapath terms
    logic [TW-1:0]                       ticks_inc;
    logic [31:0]                         gap;
    logic signed [7:0]                   step;
    logic [15:0]                         step_need;
    logic [mivu_pkg::DIV_PROD_W-1:0]     div_prod;
    logic [mivu_pkg::DIV_Q_W-1:0]        load_q;
    logic [TW-1:0]                       load_ticks;

    assign s1_adv         = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !s1_adv;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            test_mode_reg <= 1'b0;
            iv_index_reg  <= '0;
            state_reg     <= mivu_pkg::IV_NORMAL;
            ticks_reg     <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                test_mode_reg <= cfg_wdata;
            end
            if (s1_adv)
            begin
                iv_index_reg <= iv_index_next;
                state_reg    <= state_next;
                ticks_reg    <= ticks_next;
                pending_reg  <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_type;
            s1_iv_reg   <= iv_value;
            s1_flag_reg <= update_flag;
            s1_busy_reg <= transport_busy;
            s1_secs_reg <= seconds_value;
        end
        if (s1_adv)
        begin
            status_reg   <= status_next;
            cur_reg      <= iv_index_next;
            tx_reg       <= tx_next;
            prog_reg     <= (state_next == mivu_pkg::IV_IN_PROGRESS);
            pend_out_reg <= pending_next;
            clr_reg      <= clr_next;
        end
    end

    assign ticks_inc = (ticks_reg < TW'(mivu_pkg::TICKS_MAX)) ? ticks_reg + TW'(1) : ticks_reg;
    assign gap       = s1_iv_reg - iv_index_reg;

    // step = 2*gap + (flag asks normal) - (state is normal), gap already <= 42 here
    assign step = $signed({1'b0, gap[5:0], 1'b0})
                + $signed({7'd0, !s1_flag_reg})
                - $signed({7'd0, state_reg == mivu_pkg::IV_NORMAL});
    assign step_need = 16'(step[6:0]) * 16'(mivu_pkg::TICKS_96H);

    assign div_prod = mivu_pkg::DIV_PROD_W'(s1_secs_reg[23:mivu_pkg::DIV_PRE])
                    * mivu_pkg::DIV_PROD_W'(mivu_pkg::DIV_MULT);
    assign load_q   = div_prod[mivu_pkg::DIV_PROD_W-1:mivu_pkg::DIV_SHIFT];
    assign load_ticks = (TW'(load_q) > TW'(mivu_pkg::TICKS_MAX))
                      ? TW'(mivu_pkg::TICKS_MAX) : TW'(load_q);

    // next state of the iv procedure
    always_comb
    begin
        iv_index_next = iv_index_reg;
        state_next    = state_reg;
        ticks_next    = ticks_reg;
        pending_next  = pending_reg;
        status_next   = mivu_pkg::ST_OK;
        clr_next      = 1'b0;
        unique case (mivu_pkg::req_t'(s1_req_reg))
            mivu_pkg::REQ_TICK:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= TW'(mivu_pkg::TICKS_144H)
                    && state_reg == mivu_pkg::IV_IN_PROGRESS)
                begin
                    if (s1_busy_reg)
                    begin
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        state_next = mivu_pkg::IV_NORMAL;
                        ticks_next = '0;
                        clr_next   = 1'b1;
                    end
                end
            end
            mivu_pkg::REQ_BEACON:
            begin
                priority if (iv_index_reg > s1_iv_reg)
                begin
                    status_next = mivu_pkg::ST_LOWER;
                end
                else if (gap > 32'(mivu_pkg::MAX_GAP))
                begin
                    status_next = mivu_pkg::ST_GAP;
                end
                else if (step <= 8'sd0)
                begin
                    status_next = mivu_pkg::ST_OK;
                end
                else if (!test_mode_reg && 16'(ticks_reg) < step_need)
                begin
                    status_next = mivu_pkg::ST_EARLY;
                end
                else if (step == 8'sd1)
                begin
                    iv_index_next = s1_iv_reg;
                    if (!s1_flag_reg)
                    begin
                        if (s1_busy_reg)
                        begin
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            state_next = mivu_pkg::IV_NORMAL;
                            ticks_next = '0;
                            clr_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = mivu_pkg::IV_IN_PROGRESS;
                    end
                end
                else
                begin
                    // recovery
                    iv_index_next = s1_iv_reg;
                    state_next    = mivu_pkg::iv_state_t'(s1_flag_reg);
                    ticks_next    = TW'(mivu_pkg::TICKS_96H);
                    clr_next      = 1'b1;
                end
            end
            mivu_pkg::REQ_LOAD:
            begin
                iv_index_next = s1_iv_reg;
                state_next    = mivu_pkg::iv_state_t'(s1_flag_reg);
                ticks_next    = load_ticks;
            end
            default:
            begin
                status_next = mivu_pkg::ST_OK;
            end
        endcase
    end

    // transmit index from the state after the step
    always_comb
    begin
        if (state_next == mivu_pkg::IV_IN_PROGRESS)
        begin
            tx_next = iv_index_next - 32'd1;
        end
        else
        begin
            tx_next = iv_index_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign cur_iv_index    = cur_reg;
    assign tx_iv_index     = tx_reg;
    assign in_progress     = prog_reg;
    assign transit_pending = pend_out_reg;
    assign clear_pulse     = clr_reg;

    `MIVU_ASSERT(a_pending_sticky, pending_reg |=> pending_reg, "pending flag dropped")
    `MIVU_ASSERT_ALWAYS(a_ticks_bound, ticks_reg <= TW'(mivu_pkg::TICKS_MAX),
        "tick count too big")
    `MIVU_ASSERT(a_clear_ticks,
        out_valid_reg && clr_reg |-> (ticks_reg == '0 || ticks_reg == TW'(mivu_pkg::TICKS_96H)),
        "clear without tick reset")
    `MIVU_ASSERT(a_reject_no_clear,
        out_valid_reg && status_reg != mivu_pkg::ST_OK |-> !clr_reg,
        "rejected item pulsed clear")
    `MIVU_ASSERT(a_stall_full,
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall,
        "input stalled with room")

endmodule

`default_nettype wire
